// ----- sv/mkm_pkg.sv -----
// Package for the multi-key k-way merge: sizes, key type codes, compare function.
// No dependencies.
package mkm_pkg;
  localparam int RUNS = 12;
  localparam int KEY_FIELDS = 4;
  localparam int STRING_BYTES = 8;
  localparam int RUN_W = 4;
  localparam int REC_W = 31;
  localparam int KEY_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [2:0] TY_STR = 3'd0;
  localparam logic [2:0] TY_U8 = 3'd1;
  localparam logic [2:0] TY_I16 = 3'd2;
  localparam logic [2:0] TY_I64 = 3'd3;
  localparam logic [2:0] TY_F32 = 3'd4;
  localparam logic [2:0] TY_F64 = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_TYPES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DESCEND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STR_LEN = 3'd4;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [1:0] ord_t;  // 2'b01 less, 2'b10 greater, 2'b00 equal

  localparam ord_t ORD_EQ = 2'b00;
  localparam ord_t ORD_LT = 2'b01;
  localparam ord_t ORD_GT = 2'b10;

  typedef struct packed {
    logic [3:0] run_count;
    logic [2:0] field_count;
    logic [11:0] field_types;
    logic [3:0] descend_mask;
    logic [15:0] string_lengths;
  } cfg_t;

  function automatic ord_t ucmp(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    ord_t r;
    r = (a < b) ? ORD_LT : (a > b) ? ORD_GT : ORD_EQ;
    return r;
  endfunction

  // One key field; a and b are the two raw 64-bit patterns.
  function automatic ord_t cmp_field(input logic [2:0] ty, input logic desc,
                                     input logic [3:0] lenm1, input key_t a, input key_t b);
    ord_t r;
    logic [KEY_W-1:0] ma, mb;
    logic na, nb;
    logic [3:0] len;
    logic alive;
    r = ORD_EQ;
    ma = '0;
    mb = '0;
    na = 1'b0;
    nb = 1'b0;
    alive = 1'b1;
    len = (lenm1 >= 4'(STRING_BYTES)) ? 4'(STRING_BYTES) : lenm1 + 4'd1;
    case (ty)
      TY_STR: begin
        // bytes past len or past a shared zero byte read as zero
        for (int k = 0; k < STRING_BYTES; k++) begin
          if (alive && 4'(k) < len) begin
            ma[63-8*k -: 8] = a[63-8*k -: 8];
            mb[63-8*k -: 8] = b[63-8*k -: 8];
            if (a[63-8*k -: 8] == 8'd0 && b[63-8*k -: 8] == 8'd0) alive = 1'b0;
          end
        end
        return ucmp(ma, mb);
      end
      TY_U8: r = ucmp({56'd0, a[7:0]}, {56'd0, b[7:0]});
      TY_I16: r = ucmp({48'd0, ~a[15], a[14:0]}, {48'd0, ~b[15], b[14:0]});
      TY_I64: r = ucmp({~a[63], a[62:0]}, {~b[63], b[62:0]});
      TY_F32, TY_F64: begin
        if (ty == TY_F32) begin
          na = (a[30:23] == 8'hFF) && (a[22:0] != '0);
          nb = (b[30:23] == 8'hFF) && (b[22:0] != '0);
          ma = (a[30:0] == '0) ? 64'h8000_0000_0000_0000 : a[31] ?
               64'h8000_0000_0000_0000 - {33'd0, a[30:0]} :
               64'h8000_0000_0000_0000 + {33'd0, a[30:0]};
          mb = (b[30:0] == '0) ? 64'h8000_0000_0000_0000 : b[31] ?
               64'h8000_0000_0000_0000 - {33'd0, b[30:0]} :
               64'h8000_0000_0000_0000 + {33'd0, b[30:0]};
        end else begin
          na = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
          nb = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
          ma = a[63] ? ~{1'b0, a[62:0]} + 64'd1 + 64'h8000_0000_0000_0000 :
               {1'b1, a[62:0]};
          mb = b[63] ? ~{1'b0, b[62:0]} + 64'd1 + 64'h8000_0000_0000_0000 :
               {1'b1, b[62:0]};
          if (a[62:0] == '0) ma = 64'h8000_0000_0000_0000;
          if (b[62:0] == '0) mb = 64'h8000_0000_0000_0000;
        end
        if (na || nb) return (na && nb) ? ORD_EQ : (na ? ORD_LT : ORD_GT);
        r = ucmp(ma, mb);
      end
      default: return ORD_EQ;
    endcase
    return desc ? {r[0], r[1]} : r;
  endfunction
endpackage

// ----- sv/mkm_head_ram.sv -----
// Head record store: one row per run holding all key fields and the record number.
// Depends on mkm_pkg. Synchronous write, registered read.
module mkm_head_ram (
  input  logic clk,
  input  logic we,
  input  logic [mkm_pkg::RUN_W-1:0] waddr,
  input  logic [mkm_pkg::KEY_FIELDS*mkm_pkg::KEY_W+mkm_pkg::REC_W-1:0] wdata,
  input  logic [mkm_pkg::RUN_W-1:0] raddr,
  output logic [mkm_pkg::KEY_FIELDS*mkm_pkg::KEY_W+mkm_pkg::REC_W-1:0] rdata
);
  import mkm_pkg::*;
  logic [KEY_FIELDS*KEY_W+REC_W-1:0] mem [RUNS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/mkm_cmp.sv -----
// Record order: true when record a sorts strictly before record b.
// Depends on mkm_pkg (cmp_field).
module mkm_cmp (
  input  mkm_pkg::cfg_t cfg,
  input  logic [mkm_pkg::KEY_FIELDS*mkm_pkg::KEY_W+mkm_pkg::REC_W-1:0] a,
  input  logic [mkm_pkg::KEY_FIELDS*mkm_pkg::KEY_W+mkm_pkg::REC_W-1:0] b,
  output logic less
);
  import mkm_pkg::*;
  ord_t ord [KEY_FIELDS];
  logic [2:0] nf;

  always_comb begin
    nf = (cfg.field_count > 3'(KEY_FIELDS)) ? 3'(KEY_FIELDS) : cfg.field_count;
    for (int t = 0; t < KEY_FIELDS; t++) begin
      ord[t] = cmp_field(cfg.field_types[3*t +: 3], cfg.descend_mask[t],
                         cfg.string_lengths[4*t +: 4],
                         a[REC_W+KEY_W*t +: KEY_W], b[REC_W+KEY_W*t +: KEY_W]);
    end
    less = a[REC_W-1:0] < b[REC_W-1:0];
    for (int t = KEY_FIELDS - 1; t >= 0; t--) begin
      if (3'(t) < nf && ord[t] != ORD_EQ) less = (ord[t] == ORD_LT);
    end
  end
endmodule

// ----- sv/multi_key_kway_merge.sv -----
// Top level of the multi-key k-way merge: handshakes, slot flags, scan sequencer.
// Depends on mkm_pkg, mkm_head_ram, mkm_cmp.
// An accepted beat updates the slot flags and the next cycle checks them. If an active
// slot is still empty, the sequencer returns to idle and the next beat can be taken. When every
// active slot is exhausted a done beat is loaded into the output register in that check
// cycle. When at least one slot is full, the heads are read back from the head RAM one run
// per cycle and compared against the best so far (active being run_count held to 1..12);
// the best record is then presented and the next beat can be taken. A waiting result does
// not hold off the next beat, but the check and emit steps stall until the output register
// is free.
module multi_key_kway_merge (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [295:0] s_tdata,  // run, key0, key1, key2, key3, record_number, pad
  input  logic s_tuser,          // kind
  output logic m_tvalid,
  input  logic m_tready,
  output logic [295:0] m_tdata,  // out_key0..3, out_record_number, source_run, pad
  output logic m_tuser,          // done_res
  input  logic cfg_we,
  input  logic [mkm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mkm_pkg::*;
  localparam int ROW_W = KEY_FIELDS * KEY_W + REC_W;

  typedef enum logic [1:0] {IDLE, CHECK, SCAN, EMIT} state_t;
  state_t state;
  cfg_t cfg;
  logic [RUNS-1:0] full, exh;
  logic [RUN_W-1:0] active, idx, best;
  logic best_ok;
  logic [ROW_W-1:0] best_row, rdata;
  logic less, ram_we, accept, rvalid;
  logic [RUN_W-1:0] in_run, raddr;
  logic [RUNS-1:0] act_mask;
  logic [RUN_W-1:0] rd_idx;
  logic all_ready, none_full, out_free, out_set;

  assign in_run = s_tdata[3:0];
  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == IDLE);
  assign active = (cfg.run_count == '0) ? 4'd1 :
                  (cfg.run_count > 4'(RUNS)) ? 4'(RUNS) : cfg.run_count;
  assign ram_we = accept && !s_tuser && (in_run < active);
  assign raddr = idx;
  assign all_ready = ((full | exh) & act_mask) == act_mask;
  assign none_full = (full & act_mask) == '0;
  assign out_free = !m_tvalid || m_tready;
  assign out_set = out_free && (((state == CHECK) && all_ready && none_full) ||
                                (state == EMIT));

  always_comb begin
    for (int i = 0; i < RUNS; i++) act_mask[i] = (4'(i) < active);
  end

  mkm_head_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(in_run),
    .wdata({s_tdata[4+KEY_FIELDS*KEY_W +: REC_W], s_tdata[4 +: KEY_FIELDS*KEY_W]}),
    .raddr(raddr), .rdata(rdata));

  // compare row layout (cur): record number low, then key0 upward; the RAM row keeps keys low
  logic [ROW_W-1:0] cur;
  assign cur = {rdata[KEY_FIELDS*KEY_W-1:0], rdata[ROW_W-1 -: REC_W]};
  mkm_cmp u_cmp (.cfg(cfg), .a(cur), .b(best_row), .less(less));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{run_count: 4'd4, field_count: 3'd1, field_types: '0,
               descend_mask: '0, string_lengths: 16'h7777};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RUN_COUNT: cfg.run_count <= cfg_data[3:0];
        REG_FIELD_COUNT: cfg.field_count <= cfg_data[2:0];
        REG_FIELD_TYPES: cfg.field_types <= cfg_data[11:0];
        REG_DESCEND: cfg.descend_mask <= cfg_data[3:0];
        REG_STR_LEN: cfg.string_lengths <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      full <= '0;
      exh <= '0;
      m_tvalid <= 1'b0;
      idx <= '0;
      rvalid <= 1'b0;
      best_ok <= 1'b0;
    end else begin
      if (out_set) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: if (accept) begin
          if (in_run < active) begin
            full[in_run] <= !s_tuser;
            exh[in_run] <= s_tuser;
          end
          state <= CHECK;
        end
        CHECK: begin
          if (!all_ready) begin
            state <= IDLE;
          end else if (none_full) begin
            if (out_free) begin
              full <= '0;
              exh <= '0;
              m_tdata <= '0;
              m_tuser <= 1'b1;
              state <= IDLE;
            end
          end else begin
            idx <= '0;
            rvalid <= 1'b0;
            best_ok <= 1'b0;
            state <= SCAN;
          end
        end
        SCAN: begin
          rvalid <= 1'b1;
          rd_idx <= idx;
          if (rvalid && full[rd_idx] && (!best_ok || less)) begin
            best_ok <= 1'b1;
            best <= rd_idx;
            best_row <= cur;
          end
          if (rvalid && rd_idx == active - 4'd1) state <= EMIT;
          else if (idx != active - 4'd1) idx <= idx + 4'd1;
        end
        EMIT: if (out_free) begin
          full[best] <= 1'b0;
          m_tdata <= {5'd0, best, best_row[REC_W-1:0], best_row[ROW_W-1:REC_W]};
          m_tuser <= 1'b0;
          rvalid <= 1'b0;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && !$past(m_tvalid)) |-> (full == '0 && exh == '0))
    else $error("done beat left slots set");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !s_tready)
    else $error("input taken during scan");
  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> (best_ok && full[best]))
    else $error("emitting an empty slot");
endmodule
